[design/dlte_pkg.sv]
// shared types, constants and helpers of the lease table engine
package dlte_pkg;

  // storage sizes
  localparam int POOL_DEPTH    = 256;
  localparam int LEASE_ENTRIES = 256;
  localparam int PW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int LW = $clog2(LEASE_ENTRIES);

  // field widths
  localparam int KIND_W    = 2;
  localparam int MAC_W     = 48;
  localparam int XID_W     = 32;
  localparam int HOST_W    = 8;
  localparam int TIME_W    = 32;
  localparam int SHORT_W   = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // host range of the pool and register reset values
  localparam logic [HOST_W-1:0]  HOST_FIRST      = 8'd1;
  localparam logic [HOST_W-1:0]  HOST_LAST       = 8'd254;
  localparam logic [HOST_W-1:0]  SERVER_HOST_RST = 8'd1;
  localparam logic [SHORT_W-1:0] IDLE_LIMIT_RST  = 16'd60;
  localparam logic [TIME_W-1:0]  LEASE_LIMIT_RST = 32'd3600;
  localparam logic [SHORT_W-1:0] SWEEP_INTV_RST  = 16'd10;

  typedef logic [PW-1:0]     pool_idx_t;
  typedef logic [CW-1:0]     pool_cnt_t;
  typedef logic [LW-1:0]     lease_idx_t;
  typedef logic [HOST_W-1:0] host_t;
  typedef logic [MAC_W-1:0]  mac_t;
  typedef logic [TIME_W-1:0] time_t;

  typedef enum logic [KIND_W-1:0] {
    RT_DISCOVER = 2'd0,
    RT_REQUEST  = 2'd1,
    RT_RELEASE  = 2'd2,
    RT_TICK     = 2'd3
  } req_kind_t;

  typedef enum logic [KIND_W-1:0] {
    RK_OFFER = 2'd0,
    RK_ACK   = 2'd1,
    RK_NAK   = 2'd2
  } reply_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SERVER_HOST    = 2'd0,
    CFG_IDLE_LIMIT     = 2'd1,
    CFG_LEASE_LIMIT    = 2'd2,
    CFG_SWEEP_INTERVAL = 2'd3
  } cfg_idx_t;

  // one lease table word
  typedef struct packed {
    mac_t  mac;
    host_t host;
    time_t start;
    time_t limit;
  } lease_word_t;

  localparam int LEASE_W = $bits(lease_word_t);

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE, ST_BUILD_INIT, ST_BUILD, ST_DISPATCH, ST_TICK,
    ST_SW_INIT, ST_SW_RD, ST_SW_CMP, ST_SW_END,
    ST_POP_RD, ST_POP_TAKE,
    ST_LF_INIT, ST_LF_RD, ST_LF_CMP, ST_LF_END,
    ST_DISC_ADD, ST_RENEW,
    ST_PF_INIT, ST_PF_RD, ST_PF_CMP,
    ST_ER_CHK, ST_ER_RD, ST_ER_WR, ST_ER_END,
    ST_MOVE_OLD, ST_REQ_ADD, ST_NAK, ST_REL, ST_REPLY
  } state_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_BUILD_INIT, OP_BUILD_STEP, OP_TICK,
    OP_SCAN_INIT, OP_LF_CMP, OP_SW_CMP, OP_SW_TAKE,
    OP_POP_RD, OP_POP_TAKE, OP_DISC_ADD, OP_RENEW,
    OP_PF_INIT, OP_PF_CMP, OP_ER_RD, OP_ER_WR, OP_ER_END,
    OP_MOVE_OLD, OP_REQ_ADD, OP_NAK, OP_REL, OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic      build_pending;
    logic      build_last;
    logic      accepted;
    req_kind_t kind;
    logic      pool_empty;
    logic      cd_zero;
    logic      idx_last;
    logic      lf_found;
    logic      own_host;
    logic      best_found;
    logic      pf_hit;
    logic      off_last;
    logic      er_done;
    logic      out_busy;
  } sts_t;

  // ring pointer step with wrap
  function automatic pool_idx_t pool_next(pool_idx_t p);
    return (p == pool_idx_t'(POOL_DEPTH - 1)) ? '0 : pool_idx_t'(p + 1'b1);
  endfunction

endpackage

[design/dlte_msg_if.sv]
// request channel carrying one dhcp message or tick
interface dlte_msg_if;
  logic                             valid;
  logic                             ready;
  logic [dlte_pkg::KIND_W-1:0]      req_type;
  logic [dlte_pkg::MAC_W-1:0]       client_mac;
  logic [dlte_pkg::XID_W-1:0]       txn_id;
  logic [dlte_pkg::HOST_W-1:0]      requested_host;
  logic [dlte_pkg::HOST_W-1:0]      released_host;

  modport source (output valid, req_type, client_mac, txn_id,
                  requested_host, released_host, input ready);
  modport sink   (input valid, req_type, client_mac, txn_id,
                  requested_host, released_host, output ready);
endinterface

[design/dlte_reply_if.sv]
// reply channel carrying one offer, ack or nak
interface dlte_reply_if;
  logic                             valid;
  logic                             ready;
  logic [dlte_pkg::KIND_W-1:0]      reply_kind;
  logic [dlte_pkg::MAC_W-1:0]       reply_mac;
  logic [dlte_pkg::XID_W-1:0]       reply_xid;
  logic [dlte_pkg::HOST_W-1:0]      your_host;

  modport source (output valid, reply_kind, reply_mac, reply_xid, your_host,
                  input ready);
  modport sink   (input valid, reply_kind, reply_mac, reply_xid, your_host,
                  output ready);
endinterface

[design/dlte_ram.sv]
// generic simple dual port ram with registered read
module dlte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/dlte_datapath.sv]
// datapath: config registers, pool ring, lease table, scan and reply registers
module dlte_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dlte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlte_pkg::CFG_W-1:0]     cfg_data,
  input  dlte_pkg::cmd_t                 cmd,
  output dlte_pkg::sts_t                 sts,
  dlte_msg_if.sink                       msg,
  dlte_reply_if.source                   reply
);
  import dlte_pkg::*;

  // configuration
  host_t               server_host;
  logic [SHORT_W-1:0]  idle_limit;
  time_t               lease_limit;
  logic [SHORT_W-1:0]  sweep_interval;
  logic                build_pending;

  // latched request
  req_kind_t item_kind;
  mac_t      item_mac;
  logic [XID_W-1:0] item_xid;
  host_t     item_req;
  host_t     item_rel;

  // pool state
  pool_idx_t head;
  pool_cnt_t count;
  host_t     bh;
  pool_idx_t ptr;
  pool_cnt_t off;
  pool_cnt_t er_left;

  // lease scan state
  logic [LEASE_ENTRIES-1:0] lease_valid;
  lease_idx_t idx;
  logic       lf_found;
  lease_idx_t lf_idx;
  host_t      lf_host;
  time_t      lf_start;
  logic       free_found;
  lease_idx_t free_idx;
  logic       best_found;
  lease_idx_t best_idx;
  mac_t       best_mac;
  host_t      best_host;

  // time keeping
  time_t              now;
  logic [SHORT_W-1:0] cd;

  // reply build and output register
  reply_kind_t kind_r;
  host_t       your_host_r;
  logic        out_valid;
  reply_kind_t out_kind;
  mac_t        out_mac;
  logic [XID_W-1:0] out_xid;
  host_t       out_host;

  // memory ports
  logic        p_we;
  pool_idx_t   p_waddr;
  host_t       p_wdata;
  pool_idx_t   p_raddr;
  host_t       p_rdata;
  logic        l_we;
  lease_idx_t  l_waddr;
  lease_word_t l_wdata;
  lease_word_t l_rdata;

  // helpers
  logic        accepted;
  logic        pool_full;
  logic [PW+1:0] tail_sum;
  pool_idx_t   tail;
  logic        build_wr;
  logic        push_en;
  logic        push_wr;
  host_t       push_host;
  logic        clear_en;
  lease_idx_t  clear_idx;
  lease_idx_t  add_idx;
  logic        expired;
  logic        cur_valid;

  assign accepted  = msg.valid && cmd.in_ready;
  assign msg.ready = cmd.in_ready;
  assign pool_full = (count >= pool_cnt_t'(POOL_DEPTH));
  assign expired   = (time_t'(now - l_rdata.start) > l_rdata.limit);
  assign build_wr  = (bh != server_host) && !pool_full;

  // tail slot of the ring
  always_comb begin
    tail_sum = (PW + 2)'(head) + (PW + 2)'(count);
    if (tail_sum >= (PW + 2)'(POOL_DEPTH)) begin
      tail = PW'(tail_sum - (PW + 2)'(POOL_DEPTH));
    end else begin
      tail = PW'(tail_sum);
    end
  end

  // pool push source and lease invalidation
  always_comb begin
    push_en   = 1'b0;
    push_host = item_rel;
    clear_en  = 1'b0;
    clear_idx = lf_idx;
    case (cmd.op)
      OP_REL: begin
        push_en  = lf_found;
        clear_en = lf_found;
      end
      OP_MOVE_OLD: begin
        push_en   = 1'b1;
        push_host = lf_host;
        clear_en  = 1'b1;
      end
      OP_SW_TAKE: begin
        push_en   = best_found;
        push_host = best_host;
        clear_en  = best_found;
        clear_idx = best_idx;
      end
      default: ;
    endcase
    push_wr = push_en && !pool_full;
  end

  // pool ring write and read address
  always_comb begin
    p_we    = 1'b0;
    p_waddr = tail;
    p_wdata = push_host;
    case (cmd.op)
      OP_BUILD_STEP: begin
        p_we    = build_wr;
        p_waddr = count[PW-1:0];
        p_wdata = bh;
      end
      OP_ER_WR: begin
        p_we    = 1'b1;
        p_waddr = ptr;
        p_wdata = p_rdata;
      end
      default: p_we = push_wr;
    endcase
    case (cmd.op)
      OP_POP_RD: p_raddr = head;
      OP_ER_RD:  p_raddr = pool_next(ptr);
      default:   p_raddr = ptr;
    endcase
  end

  // first free entry once the old lease has gone
  assign add_idx = (lf_found && (!free_found || lf_idx < free_idx)) ? lf_idx : free_idx;

  // lease table write
  always_comb begin
    l_we    = 1'b0;
    l_waddr = free_idx;
    l_wdata = '{mac: item_mac, host: item_req, start: now, limit: lease_limit};
    case (cmd.op)
      OP_DISC_ADD: begin
        l_we    = !lf_found && free_found;
        l_wdata = '{mac: item_mac, host: your_host_r, start: now,
                    limit: TIME_W'(idle_limit)};
      end
      OP_RENEW: begin
        l_we    = 1'b1;
        l_waddr = lf_idx;
        l_wdata = '{mac: item_mac, host: lf_host, start: lf_start, limit: lease_limit};
      end
      OP_REQ_ADD: begin
        l_we    = lf_found || free_found;
        l_waddr = add_idx;
      end
      default: ;
    endcase
  end

  dlte_ram #(.WIDTH(HOST_W), .DEPTH(POOL_DEPTH)) u_pool_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  dlte_ram #(.WIDTH(LEASE_W), .DEPTH(LEASE_ENTRIES)) u_lease_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (idx),
    .rdata (l_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      server_host    <= SERVER_HOST_RST;
      idle_limit     <= IDLE_LIMIT_RST;
      lease_limit    <= LEASE_LIMIT_RST;
      sweep_interval <= SWEEP_INTV_RST;
      build_pending  <= 1'b1;
      head           <= '0;
      count          <= '0;
      now            <= '0;
      cd             <= '0;
      lease_valid    <= '0;
      out_valid      <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SERVER_HOST:    server_host    <= cfg_data[HOST_W-1:0];
          CFG_IDLE_LIMIT:     idle_limit     <= cfg_data[SHORT_W-1:0];
          CFG_LEASE_LIMIT:    lease_limit    <= cfg_data[TIME_W-1:0];
          CFG_SWEEP_INTERVAL: sweep_interval <= cfg_data[SHORT_W-1:0];
          default: ;
        endcase
      end
      // pool rebuild request
      if (cfg_we && cfg_idx_t'(cfg_index) == CFG_SERVER_HOST) begin
        build_pending <= 1'b1;
      end else if (cmd.op == OP_BUILD_INIT) begin
        build_pending <= 1'b0;
      end
      // ring head, fill count and clock
      case (cmd.op)
        OP_BUILD_INIT: begin
          head  <= '0;
          count <= '0;
        end
        OP_BUILD_STEP: if (build_wr) count <= count + 1'b1;
        OP_TICK: begin
          now <= now + 1'b1;
          if (cd == '0) begin
            cd <= (sweep_interval == '0) ? '0 : sweep_interval - 1'b1;
          end else begin
            cd <= cd - 1'b1;
          end
        end
        OP_POP_TAKE: begin
          head  <= pool_next(head);
          count <= count - 1'b1;
        end
        OP_ER_END: count <= count - 1'b1;
        default: ;
      endcase
      if (push_wr) begin
        count <= count + 1'b1;
      end
      // lease valid bits
      if (l_we) begin
        lease_valid[l_waddr] <= 1'b1;
      end
      if (clear_en) begin
        lease_valid[clear_idx] <= 1'b0;
      end
      // reply register
      if (cmd.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (reply.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    // valid bit read alongside the lease ram word
    cur_valid <= lease_valid[idx];
    if (accepted) begin
      item_kind <= req_kind_t'(msg.req_type);
      item_mac  <= msg.client_mac;
      item_xid  <= msg.txn_id;
      item_req  <= msg.requested_host;
      item_rel  <= msg.released_host;
    end
    case (cmd.op)
      OP_BUILD_INIT: bh <= HOST_FIRST;
      OP_BUILD_STEP: bh <= bh + 1'b1;
      OP_SCAN_INIT: begin
        idx        <= '0;
        lf_found   <= 1'b0;
        free_found <= 1'b0;
        best_found <= 1'b0;
      end
      OP_LF_CMP: begin
        if (cur_valid && l_rdata.mac == item_mac && !lf_found) begin
          lf_found <= 1'b1;
          lf_idx   <= idx;
          lf_host  <= l_rdata.host;
          lf_start <= l_rdata.start;
        end
        if (!cur_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= idx;
        end
        idx <= idx + 1'b1;
      end
      OP_SW_CMP: begin
        if (cur_valid && expired && (!best_found || l_rdata.mac < best_mac)) begin
          best_found <= 1'b1;
          best_idx   <= idx;
          best_mac   <= l_rdata.mac;
          best_host  <= l_rdata.host;
        end
        idx <= idx + 1'b1;
      end
      OP_POP_TAKE: your_host_r <= p_rdata;
      OP_DISC_ADD: kind_r <= RK_OFFER;
      OP_RENEW, OP_REQ_ADD: begin
        kind_r      <= RK_ACK;
        your_host_r <= item_req;
      end
      OP_NAK: begin
        kind_r      <= RK_NAK;
        your_host_r <= '0;
      end
      OP_PF_INIT: begin
        ptr <= head;
        off <= '0;
      end
      OP_PF_CMP: begin
        if (p_rdata == item_req) begin
          er_left <= count - pool_cnt_t'(1) - off;
        end else begin
          ptr <= pool_next(ptr);
          off <= off + 1'b1;
        end
      end
      OP_ER_WR: begin
        ptr     <= pool_next(ptr);
        er_left <= er_left - 1'b1;
      end
      OP_OUT: begin
        out_kind <= kind_r;
        out_mac  <= item_mac;
        out_xid  <= item_xid;
        out_host <= your_host_r;
      end
      default: ;
    endcase
  end

  // status towards the controller
  always_comb begin
    sts.build_pending = build_pending;
    sts.build_last    = (bh == HOST_LAST);
    sts.accepted      = accepted;
    sts.kind          = item_kind;
    sts.pool_empty    = (count == '0);
    sts.cd_zero       = (cd == '0);
    sts.idx_last      = (idx == lease_idx_t'(LEASE_ENTRIES - 1));
    sts.lf_found      = lf_found;
    sts.own_host      = lf_found && (lf_host == item_req);
    sts.best_found    = best_found;
    sts.pf_hit        = (p_rdata == item_req);
    sts.off_last      = (off == count - pool_cnt_t'(1));
    sts.er_done       = (er_left == '0);
    sts.out_busy      = out_valid && !reply.ready;
  end

  // reply port
  assign reply.valid      = out_valid;
  assign reply.reply_kind = out_kind;
  assign reply.reply_mac  = out_mac;
  assign reply.reply_xid  = out_xid;
  assign reply.your_host  = out_host;

endmodule

[design/dlte_ctrl.sv]
// controller state machine sequencing the datapath operations
module dlte_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  dlte_pkg::sts_t sts,
  output dlte_pkg::cmd_t cmd
);
  import dlte_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sts.build_pending) state_next = ST_BUILD_INIT;
        else if (sts.accepted) state_next = ST_DISPATCH;
      end
      ST_BUILD_INIT: state_next = ST_BUILD;
      ST_BUILD:      if (sts.build_last) state_next = ST_IDLE;
      ST_DISPATCH: begin
        case (sts.kind)
          RT_TICK:     state_next = ST_TICK;
          RT_DISCOVER: state_next = sts.pool_empty ? ST_IDLE : ST_POP_RD;
          default:     state_next = ST_LF_INIT;
        endcase
      end
      ST_TICK:     state_next = sts.cd_zero ? ST_SW_INIT : ST_IDLE;
      ST_SW_INIT:  state_next = ST_SW_RD;
      ST_SW_RD:    state_next = ST_SW_CMP;
      ST_SW_CMP:   state_next = sts.idx_last ? ST_SW_END : ST_SW_RD;
      ST_SW_END:   state_next = sts.best_found ? ST_SW_INIT : ST_IDLE;
      ST_POP_RD:   state_next = ST_POP_TAKE;
      ST_POP_TAKE: state_next = ST_LF_INIT;
      ST_LF_INIT:  state_next = ST_LF_RD;
      ST_LF_RD:    state_next = ST_LF_CMP;
      ST_LF_CMP:   state_next = sts.idx_last ? ST_LF_END : ST_LF_RD;
      ST_LF_END: begin
        case (sts.kind)
          RT_DISCOVER: state_next = ST_DISC_ADD;
          RT_RELEASE:  state_next = ST_REL;
          default:     state_next = sts.own_host ? ST_RENEW : ST_PF_INIT;
        endcase
      end
      ST_DISC_ADD: state_next = ST_REPLY;
      ST_RENEW:    state_next = ST_REPLY;
      ST_PF_INIT:  state_next = sts.pool_empty ? ST_NAK : ST_PF_RD;
      ST_PF_RD:    state_next = ST_PF_CMP;
      ST_PF_CMP: begin
        if (sts.pf_hit)        state_next = ST_ER_CHK;
        else if (sts.off_last) state_next = ST_NAK;
        else                   state_next = ST_PF_RD;
      end
      ST_ER_CHK:   state_next = sts.er_done ? ST_ER_END : ST_ER_RD;
      ST_ER_RD:    state_next = ST_ER_WR;
      ST_ER_WR:    state_next = ST_ER_CHK;
      ST_ER_END:   state_next = sts.lf_found ? ST_MOVE_OLD : ST_REQ_ADD;
      ST_MOVE_OLD: state_next = ST_REQ_ADD;
      ST_REQ_ADD:  state_next = ST_REPLY;
      ST_NAK:      state_next = ST_REPLY;
      ST_REL:      state_next = ST_IDLE;
      ST_REPLY:    if (!sts.out_busy) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd.in_ready = (state == ST_IDLE) && !sts.build_pending;
    case (state)
      ST_BUILD_INIT: cmd.op = OP_BUILD_INIT;
      ST_BUILD:      cmd.op = OP_BUILD_STEP;
      ST_TICK:       cmd.op = OP_TICK;
      ST_SW_INIT:    cmd.op = OP_SCAN_INIT;
      ST_SW_CMP:     cmd.op = OP_SW_CMP;
      ST_SW_END:     cmd.op = OP_SW_TAKE;
      ST_POP_RD:     cmd.op = OP_POP_RD;
      ST_POP_TAKE:   cmd.op = OP_POP_TAKE;
      ST_LF_INIT:    cmd.op = OP_SCAN_INIT;
      ST_LF_CMP:     cmd.op = OP_LF_CMP;
      ST_DISC_ADD:   cmd.op = OP_DISC_ADD;
      ST_RENEW:      cmd.op = OP_RENEW;
      ST_PF_INIT:    cmd.op = OP_PF_INIT;
      ST_PF_CMP:     cmd.op = OP_PF_CMP;
      ST_ER_RD:      cmd.op = OP_ER_RD;
      ST_ER_WR:      cmd.op = OP_ER_WR;
      ST_ER_END:     cmd.op = OP_ER_END;
      ST_MOVE_OLD:   cmd.op = OP_MOVE_OLD;
      ST_REQ_ADD:    cmd.op = OP_REQ_ADD;
      ST_NAK:        cmd.op = OP_NAK;
      ST_REL:        cmd.op = OP_REL;
      ST_REPLY:      cmd.op = sts.out_busy ? OP_NONE : OP_OUT;
      default:       cmd.op = OP_NONE;
    endcase
  end

endmodule

[design/dhcp_lease_table_engine_top.sv]
// top level of the dhcp address lease engine
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------------------
//  msg      | in  | valid / ready | req_type, client_mac, txn_id, hosts
//  reply    | out | valid / ready | reply_kind, reply_mac, reply_xid, your_host
//  cfg      | in  | cfg_we        | cfg_index, cfg_data (write only)
//
// one request at a time; a lease lookup walks the lease ram entry by entry,
// with a read state and a compare state for each entry, and a request for a
// new host adds a pool search up to the match and a pool shift for each entry
// behind it.
// a tick that sweeps makes one pass over the lease table for each expired
// lease plus one more pass; other ticks do not sweep.
// after reset and after a server_host write the pool is rebuilt, during which
// msg.ready stays low.
// a reply waits in the output register; the next request is taken meanwhile.
module dhcp_lease_table_engine_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dlte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlte_pkg::CFG_W-1:0]     cfg_data,
  dlte_msg_if.sink                       msg,
  dlte_reply_if.source                   reply
);
  import dlte_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  dlte_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // storage and arithmetic
  dlte_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .msg       (msg),
    .reply     (reply)
  );

endmodule
